[rtl/core/tbcr_pkg.sv]
// shared constants, types and helpers for the threshold blob centroid core
package tbcr_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int EWW   = $clog2(MAX_WIDTH + 1);
    localparam int EHW   = $clog2(MAX_HEIGHT + 1);
    localparam int PW    = (XW > YW) ? XW : YW;
    localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SUM_W = CNT_W + PW;
    localparam int DCW   = $clog2(SUM_W);

    localparam int PIXEL_W    = 8;
    localparam int THRESH_W   = 9;
    localparam int SIZE_W     = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CENTER_W   = 10;
    localparam int RADIUS_W   = 9;
    localparam int TOTAL_W    = 21;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 9'd128;
    localparam logic [SIZE_W-1:0]   SIZE_RESET   = 11'd1024;

    typedef enum logic [2:0] {
        S_ACC,
        S_XGO,
        S_XRUN,
        S_YGO,
        S_YRUN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic pixel_en;
        logic white;
    } t_acc_ctl;

    typedef struct packed {
        logic [SUM_W-1:0] col_sum;
        logic [SUM_W-1:0] row_sum;
        logic [CNT_W-1:0] count;
        logic [EWW-1:0]   left;
        logic [XW-1:0]    right;
        logic [EHW-1:0]   top;
        logic [YW-1:0]    bottom;
    } t_stats;

    function automatic logic [EWW-1:0] eff_width(input logic [SIZE_W-1:0] v);
        logic [EWW-1:0] res;
        if (v == '0) begin
            res = EWW'(1);
        end else if (32'(v) > 32'(MAX_WIDTH)) begin
            res = EWW'(MAX_WIDTH);
        end else begin
            res = EWW'(v);
        end
        return res;
    endfunction

    function automatic logic [EHW-1:0] eff_height(input logic [SIZE_W-1:0] v);
        logic [EHW-1:0] res;
        if (v == '0) begin
            res = EHW'(1);
        end else if (32'(v) > 32'(MAX_HEIGHT)) begin
            res = EHW'(MAX_HEIGHT);
        end else begin
            res = EHW'(v);
        end
        return res;
    endfunction

endpackage

[rtl/core/threshold_blob_centroid_radius_core.sv]
// top level: frame sequencer, configuration registers and result register
// Takes one 8-bit pixel per cycle in raster order while a frame is in progress.
// After the last pixel of a frame the input is not ready while one shared serial
// divider forms the mean column and then the mean row, one quotient bit per cycle;
// a frame with no white pixel skips the divider. The result then moves into the output
// register; if the previous result there has not been taken yet, the input stays
// stalled until it is. A write of frame width or height restarts the frame.
module threshold_blob_centroid_radius_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tbcr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tbcr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [tbcr_pkg::PIXEL_W-1:0]       i_pixel,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [tbcr_pkg::CENTER_W-1:0]      o_center_x,
    output logic [tbcr_pkg::CENTER_W-1:0]      o_center_y,
    output logic [tbcr_pkg::RADIUS_W-1:0]      o_radius,
    output logic [tbcr_pkg::TOTAL_W-1:0]       o_white_total,
    output logic                               o_no_white
);
    import tbcr_pkg::*;

    t_state              r_state, n_state;
    logic [THRESH_W-1:0] r_threshold;
    logic [SIZE_W-1:0]   r_width;
    logic [SIZE_W-1:0]   r_height;
    logic [EWW-1:0]      width_eff;
    logic [EHW-1:0]      height_eff;

    t_acc_ctl            acc_ctl;
    t_stats              stats;
    logic                last_pixel;
    logic                accept;
    logic                size_write;

    logic                div_start;
    logic [SUM_W-1:0]    div_dividend;
    logic                div_done;
    logic [SUM_W-1:0]    div_quot;

    logic [CENTER_W-1:0] r_qx, n_qx;
    logic                emit;
    logic                empty;
    logic [EWW-1:0]      dx;
    logic [EHW-1:0]      dy;
    logic [PW:0]         half_sum;

    logic                r_out_valid;
    logic [CENTER_W-1:0] r_center_x;
    logic [CENTER_W-1:0] r_center_y;
    logic [RADIUS_W-1:0] r_radius;
    logic [TOTAL_W-1:0]  r_white_total;
    logic                r_no_white;

    assign width_eff  = eff_width(r_width);
    assign height_eff = eff_height(r_height);

    assign o_in_ready = (r_state == S_ACC);
    assign accept     = i_in_valid && o_in_ready;
    assign size_write = i_cfg_we &&
                        ((i_cfg_index == REG_FRAME_WIDTH) || (i_cfg_index == REG_FRAME_HEIGHT));

    assign acc_ctl.clear    = emit || size_write;
    assign acc_ctl.pixel_en = accept;
    assign acc_ctl.white    = {1'b0, i_pixel} >= r_threshold;

    tbcr_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (acc_ctl),
        .i_width  (width_eff),
        .i_height (height_eff),
        .o_last   (last_pixel),
        .o_stats  (stats)
    );

    tbcr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (stats.count),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign empty    = (stats.count == '0);
    assign dx       = (EWW'(stats.right) >= stats.left) ? EWW'(stats.right) - stats.left : '0;
    assign dy       = (EHW'(stats.bottom) >= stats.top) ? EHW'(stats.bottom) - stats.top : '0;
    assign half_sum = (PW + 1)'(dx >> 1) + (PW + 1)'(dy >> 1);

    always_comb begin
        n_state      = r_state;
        n_qx         = r_qx;
        div_start    = 1'b0;
        div_dividend = stats.col_sum;
        emit         = 1'b0;
        unique case (r_state)
            S_ACC: begin
                if (accept && last_pixel && !size_write) begin
                    n_state = S_XGO;
                end
            end
            S_XGO: begin
                if (empty) begin
                    n_state = S_EMIT;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_XRUN;
                end
            end
            S_XRUN: begin
                if (div_done) begin
                    n_qx    = CENTER_W'(div_quot);
                    n_state = S_YGO;
                end
            end
            S_YGO: begin
                div_start    = 1'b1;
                div_dividend = stats.row_sum;
                n_state      = S_YRUN;
            end
            S_YRUN: begin
                if (div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    emit    = 1'b1;
                    n_state = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_out_valid <= 1'b0;
            r_threshold <= THRESH_RESET;
            r_width     <= SIZE_RESET;
            r_height    <= SIZE_RESET;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_THRESHOLD:    r_threshold <= i_cfg_data[THRESH_W-1:0];
                    REG_FRAME_WIDTH:  r_width     <= i_cfg_data[SIZE_W-1:0];
                    REG_FRAME_HEIGHT: r_height    <= i_cfg_data[SIZE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_qx <= n_qx;
        if (emit) begin
            r_no_white    <= empty;
            r_center_x    <= empty ? '0 : r_qx;
            r_center_y    <= empty ? '0 : CENTER_W'(div_quot);
            r_radius      <= empty ? '0 : RADIUS_W'(half_sum >> 1);
            r_white_total <= TOTAL_W'(stats.count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_center_x    = r_center_x;
    assign o_center_y    = r_center_y;
    assign o_radius      = r_radius;
    assign o_white_total = r_white_total;
    assign o_no_white    = r_no_white;

endmodule

[rtl/core/tbcr_accum.sv]
// raster position counters, coordinate sums, white count and bounding box
module tbcr_accum (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tbcr_pkg::t_acc_ctl      i_ctl,
    input  logic [tbcr_pkg::EWW-1:0] i_width,
    input  logic [tbcr_pkg::EHW-1:0] i_height,
    output logic                    o_last,
    output tbcr_pkg::t_stats        o_stats
);
    import tbcr_pkg::*;

    logic [XW-1:0] r_col, n_col;
    logic [YW-1:0] r_row, n_row;
    t_stats        r_st, n_st;
    logic          col_end;
    logic          row_end;

    assign col_end = (EWW'(r_col) + EWW'(1)) == i_width;
    assign row_end = (EHW'(r_row) + EHW'(1)) == i_height;
    assign o_last  = col_end && row_end;
    assign o_stats = r_st;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_st  = r_st;
        if (i_ctl.clear) begin
            n_col          = '0;
            n_row          = '0;
            n_st.col_sum   = '0;
            n_st.row_sum   = '0;
            n_st.count     = '0;
            n_st.left      = EWW'(MAX_WIDTH);
            n_st.right     = '0;
            n_st.top       = EHW'(MAX_HEIGHT);
            n_st.bottom    = '0;
        end else if (i_ctl.pixel_en) begin
            if (i_ctl.white) begin
                n_st.col_sum = r_st.col_sum + SUM_W'(r_col);
                n_st.row_sum = r_st.row_sum + SUM_W'(r_row);
                n_st.count   = r_st.count + CNT_W'(1);
                if (EWW'(r_col) < r_st.left) begin
                    n_st.left = EWW'(r_col);
                end
                if (r_col > r_st.right) begin
                    n_st.right = r_col;
                end
                if (EHW'(r_row) < r_st.top) begin
                    n_st.top = EHW'(r_row);
                end
                if (r_row > r_st.bottom) begin
                    n_st.bottom = r_row;
                end
            end
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + YW'(1);
            end else begin
                n_col = r_col + XW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_st.col_sum <= '0;
            r_st.row_sum <= '0;
            r_st.count   <= '0;
            r_st.left    <= EWW'(MAX_WIDTH);
            r_st.right   <= '0;
            r_st.top     <= EHW'(MAX_HEIGHT);
            r_st.bottom  <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_st  <= n_st;
        end
    end

endmodule

[rtl/core/tbcr_div.sv]
// shared restoring divider, one quotient bit per cycle
module tbcr_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tbcr_pkg::SUM_W-1:0] i_dividend,
    input  logic [tbcr_pkg::CNT_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [tbcr_pkg::SUM_W-1:0] o_quot
);
    import tbcr_pkg::*;

    logic [CNT_W-1:0] r_rem, n_rem;
    logic [SUM_W-1:0] r_quo, n_quo;
    logic [CNT_W-1:0] r_dvs, n_dvs;
    logic [DCW-1:0]   r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W:0]   shifted;
    logic             ge;

    assign shifted = {r_rem, r_quo[SUM_W-1]};
    assign ge      = shifted >= {1'b0, r_dvs};
    assign o_done  = r_done;
    assign o_quot  = r_quo;

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = ge ? CNT_W'(shifted - {1'b0, r_dvs}) : CNT_W'(shifted);
            n_quo = {r_quo[SUM_W-2:0], ge};
            n_cnt = r_cnt + DCW'(1);
            if (r_cnt == DCW'(SUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_cnt <= n_cnt;
    end

endmodule

[verif/threshold_blob_centroid_radius_core_tb.sv]
// testbench for the threshold blob centroid core: directed and random frames
`timescale 1ns / 100ps

module threshold_blob_centroid_radius_core_tb;
    import tbcr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 200;
    localparam int RANDOM_WORDS  = 80;

    typedef struct packed {
        logic [CENTER_W-1:0] cx;
        logic [CENTER_W-1:0] cy;
        logic [RADIUS_W-1:0] rad;
        logic [TOTAL_W-1:0]  total;
        logic                empty;
    } t_blob;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKED} t_rx_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [PIXEL_W-1:0]    i_pixel     = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [CENTER_W-1:0]   o_center_x;
    logic [CENTER_W-1:0]   o_center_y;
    logic [RADIUS_W-1:0]   o_radius;
    logic [TOTAL_W-1:0]    o_white_total;
    logic                  o_no_white;

    // predictor state
    logic [THRESH_W-1:0] cur_thresh;
    logic [SIZE_W-1:0]   cur_width;
    logic [SIZE_W-1:0]   cur_height;
    int unsigned         col_at, row_at, lit_count, lo_x, hi_x, lo_y, hi_y;
    longint unsigned     x_sum, y_sum;
    t_blob               blob_q[$];
    t_blob               want_blob;

    int       errors    = 0;
    int       cycles    = 0;
    int       burst_left = 0;
    int       rx_count  = 0;
    t_rx_mode rx_mode   = RX_OPEN;

    threshold_blob_centroid_radius_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel       (i_pixel),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_center_x    (o_center_x),
        .o_center_y    (o_center_y),
        .o_radius      (o_radius),
        .o_white_total (o_white_total),
        .o_no_white    (o_no_white)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned span_of(logic [SIZE_W-1:0] v, int unsigned limit);
        if (v == '0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    function automatic void clear_frame();
        col_at    = 0;
        row_at    = 0;
        x_sum     = 0;
        y_sum     = 0;
        lit_count = 0;
        lo_x      = span_of(cur_width, MAX_WIDTH);
        hi_x      = 0;
        lo_y      = span_of(cur_height, MAX_HEIGHT);
        hi_y      = 0;
    endfunction

    function automatic void reset_predictor();
        cur_thresh = THRESH_RESET;
        cur_width  = SIZE_RESET;
        cur_height = SIZE_RESET;
        clear_frame();
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_THRESHOLD: begin
                cur_thresh = data[THRESH_W-1:0];
            end
            REG_FRAME_WIDTH: begin
                cur_width = data;
                clear_frame();
            end
            REG_FRAME_HEIGHT: begin
                cur_height = data;
                clear_frame();
            end
            default: begin
            end
        endcase
    endfunction

    // accumulate one pixel, queue the blob word at the end of a frame
    function automatic void track_pixel(logic [PIXEL_W-1:0] pix);
        int unsigned w, h, dx, dy;
        t_blob b;
        w = span_of(cur_width, MAX_WIDTH);
        h = span_of(cur_height, MAX_HEIGHT);
        if (pix >= cur_thresh) begin
            x_sum += col_at;
            y_sum += row_at;
            lit_count++;
            if (col_at < lo_x) lo_x = col_at;
            if (col_at > hi_x) hi_x = col_at;
            if (row_at < lo_y) lo_y = row_at;
            if (row_at > hi_y) hi_y = row_at;
        end
        if (col_at + 1 < w) begin
            col_at++;
            return;
        end
        col_at = 0;
        if (row_at + 1 < h) begin
            row_at++;
            return;
        end
        b = '0;
        if (lit_count == 0) begin
            b.empty = 1'b1;
        end else begin
            dx      = (hi_x >= lo_x) ? hi_x - lo_x : 0;
            dy      = (hi_y >= lo_y) ? hi_y - lo_y : 0;
            b.cx    = CENTER_W'(x_sum / lit_count);
            b.cy    = CENTER_W'(y_sum / lit_count);
            b.rad   = RADIUS_W'((dx / 2 + dy / 2) / 2);
            b.total = TOTAL_W'(lit_count);
        end
        blob_q.push_back(b);
        clear_frame();
    endfunction

    function automatic void check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (blob_q.size() == 0) begin
                $display("%0t: unexpected word: expected none, got cx %0d cy %0d r %0d n %0d e %0b",
                         $time, o_center_x, o_center_y, o_radius, o_white_total, o_no_white);
                errors++;
            end else begin
                want_blob = blob_q.pop_front();
                check_field("center_x", want_blob.cx, o_center_x);
                check_field("center_y", want_blob.cy, o_center_y);
                check_field("radius", want_blob.rad, o_radius);
                check_field("white_total", want_blob.total, o_white_total);
                check_field("no_white", want_blob.empty, o_no_white);
            end
        end
    end

    always @(posedge i_clk) begin
        rx_count++;
        if (rx_count % 150 == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_OPEN:    i_out_ready <= 1'b1;
            RX_COIN:    i_out_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE:  i_out_ready <= ($urandom_range(0, 4) == 0);
            RX_BLOCKED: i_out_ready <= (rx_count % 24 == 0);
            default:    i_out_ready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 12) : $urandom_range(0, 1);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_pixel    <= pix;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        track_pixel(pix);
    endtask

    // hold off the sender until every blob word is back and the core is quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (blob_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // n pixels, value lit at positions mark_a and mark_b, darker elsewhere
    task automatic send_marked(input int n, input int mark_a, input int mark_b,
                               input logic [PIXEL_W-1:0] lit);
        for (int i = 0; i < n; i++) begin
            if (i == mark_a || i == mark_b) send_pixel(lit);
            else send_pixel(PIXEL_W'($urandom_range(0, int'(lit) - 1)));
        end
    endtask

    task automatic test_default_setup();
        settle();
        send_marked(6, 1, 4, 8'd200);
        settle();
        write_reg(REG_FRAME_HEIGHT, 11'd1);
        send_marked(1024, 3, 700, 8'd128);
    endtask

    task automatic test_threshold_edges();
        settle();
        write_reg(REG_FRAME_WIDTH, 11'd0);
        write_reg(REG_FRAME_HEIGHT, 11'd0);
        write_reg(REG_THRESHOLD, 11'd0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        settle();
        write_reg(REG_THRESHOLD, 11'd255);
        send_pixel(8'd254);
        send_pixel(8'd255);
        settle();
        write_reg(REG_THRESHOLD, 11'd256);
        send_pixel(8'd255);
        settle();
        write_reg(REG_THRESHOLD, 11'h7ff);
        send_pixel(8'd255);
        settle();
        write_reg(REG_THRESHOLD, 11'd1);
        send_pixel(8'd0);
        send_pixel(8'd1);
    endtask

    task automatic test_dark_frame();
        settle();
        write_reg(REG_THRESHOLD, 11'd200);
        write_reg(REG_FRAME_WIDTH, 11'd3);
        write_reg(REG_FRAME_HEIGHT, 11'd2);
        send_marked(6, -1, -1, 8'd200);
    endtask

    task automatic test_config_mid_frame();
        settle();
        write_reg(REG_THRESHOLD, 11'd100);
        write_reg(REG_FRAME_WIDTH, 11'd4);
        write_reg(REG_FRAME_HEIGHT, 11'd3);
        send_pixel(8'd150);
        send_pixel(8'd50);
        send_pixel(8'd99);
        send_pixel(8'd100);
        send_pixel(8'd120);
        settle();
        write_reg(REG_THRESHOLD, 11'd60);
        send_pixel(8'd50);
        send_pixel(8'd70);
        send_pixel(8'd200);
        send_pixel(8'd10);
        send_pixel(8'd59);
        send_pixel(8'd60);
        send_pixel(8'd255);
        send_marked(3, 0, 2, 8'd255);
        settle();
        write_reg(REG_SPARE, 11'd5);
        send_marked(2, 1, -1, 8'd255);
        settle();
        write_reg(REG_FRAME_HEIGHT, 11'd2);
        send_marked(8, 2, 5, 8'd90);
    endtask

    task automatic test_size_limits();
        settle();
        write_reg(REG_THRESHOLD, 11'd128);
        write_reg(REG_FRAME_WIDTH, 11'd1);
        write_reg(REG_FRAME_HEIGHT, 11'd0);
        send_marked(3, 0, 2, 8'd255);
        settle();
        write_reg(REG_FRAME_WIDTH, 11'd0);
        write_reg(REG_FRAME_HEIGHT, 11'd3);
        send_marked(6, 1, 5, 8'd255);
        settle();
        write_reg(REG_FRAME_WIDTH, 11'd7);
        write_reg(REG_FRAME_HEIGHT, 11'd1);
        send_marked(7, 0, 6, 8'd255);
    endtask

    task automatic test_random_frames();
        int sent, w, h, pixels, frames, style, cut_at, v;
        logic [CFG_DATA_W-1:0] t;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            settle();
            case ($urandom_range(0, 9))
                0:       t = '0;
                1:       t = CFG_DATA_W'(255);
                2:       t = CFG_DATA_W'($urandom_range(256, 2047));
                default: t = CFG_DATA_W'($urandom_range(1, 255));
            endcase
            case ($urandom_range(0, 15))
                0: begin
                    w = 0;
                    h = $urandom_range(1, 6);
                end
                1: begin
                    w = $urandom_range(9, 40);
                    h = $urandom_range(1, 3);
                end
                2: begin
                    w = $urandom_range(1, 3);
                    h = $urandom_range(9, 30);
                end
                3: begin
                    w = $urandom_range(1, 8);
                    h = 0;
                end
                default: begin
                    w = $urandom_range(1, 8);
                    h = $urandom_range(1, 6);
                end
            endcase
            write_reg(REG_THRESHOLD, t);
            write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
            write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
            pixels = span_of(SIZE_W'(w), MAX_WIDTH) * span_of(SIZE_W'(h), MAX_HEIGHT);
            frames = $urandom_range(1, 5);
            style  = $urandom_range(0, 3);
            cut_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, frames * pixels - 1) : -1;
            for (int i = 0; i < frames * pixels; i++) begin
                if (i == cut_at) begin
                    settle();
                    if ($urandom_range(0, 1) == 1) begin
                        write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 300)));
                    end else begin
                        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
                    end
                end
                case (style)
                    0: v = $urandom_range(0, 255);
                    1: v = ($urandom_range(0, 9) == 0) ? 255 - $urandom_range(0, 40)
                                                       : $urandom_range(0, 40);
                    2: v = int'(cur_thresh) + $urandom_range(0, 6) - 3;
                    default: v = ($urandom_range(0, 1) == 1) ? 255 : 0;
                endcase
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                send_pixel(PIXEL_W'(v));
                sent++;
            end
        end
    endtask

    initial begin
        reset_predictor();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_setup();
        test_threshold_edges();
        test_dark_frame();
        test_config_mid_frame();
        test_size_limits();
        test_random_frames();
        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
